/* hw/rtl/iprf_pkg.sv */
// ----------------------------------------------------------------------------
// iprf_pkg
// Types and constants for the ICMP probe reply filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iprf_pkg;

    localparam int CAPTURE_BYTES = 64;
    localparam int COUNT_W       = $clog2(CAPTURE_BYTES + 1);
    // Offsets reach outer (60) + 8 + quoted (60) + 7, so eight bits suffice
    localparam int POS_W         = 8;

    localparam logic [15:0] OUR_IDENT_RESET = 16'h534D;
    localparam logic [3:0]  NIBBLE_MASK     = 4'h0F;
    localparam int          MIN_PACKET      = 28;
    localparam int          MIN_IP_HEADER   = 20;
    localparam logic [7:0]  UDP_PROTOCOL    = 8'd17;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_ECHO          = 8'd8;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARMED          = 3'd0,
        REG_PROBE_SEQUENCE = 3'd1,
        REG_PROBE_IDENT    = 3'd2,
        REG_UDP_PROBE_MODE = 3'd3,
        REG_UDP_SRC_PORT   = 3'd4,
        REG_UDP_DST_PORT   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        VERDICT_NOT_OURS      = 2'd0,
        VERDICT_ECHO_REPLY    = 2'd1,
        VERDICT_TIME_EXCEEDED = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        last_byte;
        logic [31:0] sender_address;
    } pkt_beat_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] hop_address;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/icmp_probe_reply_filter_unit.sv */
// ----------------------------------------------------------------------------
// icmp_probe_reply_filter_unit
// Byte-wide IPv4 ICMP parser that flags replies to our outstanding probe.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// pkt      in   pkt_valid/pkt_ready  pkt_data   (packet_byte, last_byte, sender)
// res      out  res_valid/res_ready  res_data   (verdict, hop_address)
// cfg      in   cfg_we               cfg_index, cfg_data
//
// One packet byte is taken every cycle while pkt_ready is high; parse state updates on the same edge.
// The verdict for a packet is registered on the edge that takes its last byte
// and drives res straight from that register.
// pkt_ready drops only while a result is held and res_ready is low.
// Asynchronous active-low reset clears parse state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_probe_reply_filter_unit
    import iprf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pkt_valid,
    output logic                       pkt_ready,
    input  wire pkt_beat_t             pkt_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output result_t                    res_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic        armed_reg;
    logic [15:0] probe_sequence_reg;
    logic [15:0] probe_ident_reg;
    logic        udp_probe_mode_reg;
    logic [15:0] udp_source_port_reg;
    logic [15:0] udp_dest_port_reg;

    // parse state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [5:0]  outer_len_reg, outer_len_next;
    logic [5:0]  inner_len_reg, inner_len_next;
    logic [7:0]  outer_type_reg, outer_type_next;
    logic [15:0] reply_ident_reg, reply_ident_next;
    logic [15:0] reply_seq_reg, reply_seq_next;
    logic [7:0]  q_proto_reg, q_proto_next;
    logic [15:0] q_first_reg, q_first_next;
    logic [15:0] q_second_reg, q_second_next;
    logic [7:0]  q_type_reg, q_type_next;
    logic [15:0] q_ident_reg, q_ident_next;
    logic [15:0] q_seq_reg, q_seq_next;

    logic        res_valid_reg, res_valid_next;
    result_t     res_data_reg, res_data_next;

    logic        accept;
    logic [7:0]  b;
    logic [POS_W-1:0] pos, inner_pos, q_pos, n;
    verdict_t    verdict;

    function automatic logic [15:0] take_word(input logic [15:0] w,
                                              input logic [POS_W-1:0] at,
                                              input logic [POS_W-1:0] p,
                                              input logic [7:0] d);
        logic [15:0] r;
        r = w;
        if (p == at)
            r = {d, w[7:0]};
        if (p == at + POS_W'(1))
            r = {w[15:8], d};
        return r;
    endfunction

    assign pkt_ready = !res_valid_reg || res_ready;
    assign accept    = pkt_valid && pkt_ready;
    assign b         = pkt_data.packet_byte;
    assign pos       = POS_W'(byte_count_reg);

    // Field capture for the current byte; later offsets see lengths taken
    // from this same byte.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        outer_len_next  = outer_len_reg;
        inner_len_next  = inner_len_reg;
        outer_type_next = outer_type_reg;
        reply_ident_next = reply_ident_reg;
        reply_seq_next  = reply_seq_reg;
        q_proto_next    = q_proto_reg;
        q_first_next    = q_first_reg;
        q_second_next   = q_second_reg;
        q_type_next     = q_type_reg;
        q_ident_next    = q_ident_reg;
        q_seq_next      = q_seq_reg;
        inner_pos       = POS_W'(outer_len_reg) + POS_W'(8);
        q_pos           = inner_pos + POS_W'(inner_len_reg);

        if (byte_count_reg < COUNT_W'(CAPTURE_BYTES))
        begin
            byte_count_next = byte_count_reg + COUNT_W'(1);
            if (byte_count_reg == '0)
                outer_len_next = {b[3:0] & NIBBLE_MASK, 2'b00};
            if (pos == POS_W'(outer_len_next))
                outer_type_next = b;
            reply_ident_next = take_word(reply_ident_reg,
                                         POS_W'(outer_len_next) + POS_W'(4), pos, b);
            reply_seq_next   = take_word(reply_seq_reg,
                                         POS_W'(outer_len_next) + POS_W'(6), pos, b);
            inner_pos = POS_W'(outer_len_next) + POS_W'(8);
            if (pos == inner_pos)
                inner_len_next = {b[3:0] & NIBBLE_MASK, 2'b00};
            q_pos = inner_pos + POS_W'(inner_len_next);
            if (pos >= inner_pos)
            begin
                if (pos == inner_pos + POS_W'(9))
                    q_proto_next = b;
                if (pos == q_pos)
                    q_type_next = b;
                q_first_next  = take_word(q_first_reg,  q_pos,              pos, b);
                q_second_next = take_word(q_second_reg, q_pos + POS_W'(2), pos, b);
                q_ident_next  = take_word(q_ident_reg,  q_pos + POS_W'(4), pos, b);
                q_seq_next    = take_word(q_seq_reg,    q_pos + POS_W'(6), pos, b);
            end
        end
    end

    // Verdict from the state as it stands after this byte
    always_comb
    begin
        n       = POS_W'(byte_count_next);
        verdict = VERDICT_NOT_OURS;
        if (armed_reg && n >= POS_W'(MIN_PACKET)
            && n >= POS_W'(outer_len_next) + POS_W'(8))
        begin
            if (outer_type_next == TYPE_ECHO_REPLY)
            begin
                if (reply_ident_next == probe_ident_reg
                    && reply_seq_next == probe_sequence_reg)
                    verdict = VERDICT_ECHO_REPLY;
            end
            else if (outer_type_next == TYPE_TIME_EXCEEDED
                     && n >= inner_pos + POS_W'(MIN_IP_HEADER + 8)
                     && n >= q_pos + POS_W'(8))
            begin
                if (udp_probe_mode_reg)
                begin
                    if (q_proto_next == UDP_PROTOCOL
                        && q_first_next == udp_source_port_reg
                        && q_second_next == udp_dest_port_reg)
                        verdict = VERDICT_TIME_EXCEEDED;
                end
                else if (q_type_next == TYPE_ECHO && q_ident_next == probe_ident_reg
                         && q_seq_next == probe_sequence_reg)
                    verdict = VERDICT_TIME_EXCEEDED;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        if (accept && pkt_data.last_byte)
        begin
            res_valid_next            = 1'b1;
            res_data_next.verdict     = verdict;
            res_data_next.hop_address = (verdict != VERDICT_NOT_OURS)
                                        ? pkt_data.sender_address : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg           <= 1'b0;
            probe_sequence_reg  <= 16'd0;
            probe_ident_reg     <= OUR_IDENT_RESET;
            udp_probe_mode_reg  <= 1'b0;
            udp_source_port_reg <= 16'd0;
            udp_dest_port_reg   <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ARMED:          armed_reg           <= cfg_data[0];
                REG_PROBE_SEQUENCE: probe_sequence_reg  <= cfg_data;
                REG_PROBE_IDENT:    probe_ident_reg     <= cfg_data;
                REG_UDP_PROBE_MODE: udp_probe_mode_reg  <= cfg_data[0];
                REG_UDP_SRC_PORT:   udp_source_port_reg <= cfg_data;
                REG_UDP_DST_PORT:   udp_dest_port_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            outer_len_reg   <= '0;
            inner_len_reg   <= '0;
            outer_type_reg  <= '0;
            reply_ident_reg <= '0;
            reply_seq_reg   <= '0;
            q_proto_reg     <= '0;
            q_first_reg     <= '0;
            q_second_reg    <= '0;
            q_type_reg      <= '0;
            q_ident_reg     <= '0;
            q_seq_reg       <= '0;
        end
        else if (accept)
        begin
            if (pkt_data.last_byte)
            begin
                byte_count_reg  <= '0;
                outer_len_reg   <= '0;
                inner_len_reg   <= '0;
                outer_type_reg  <= '0;
                reply_ident_reg <= '0;
                reply_seq_reg   <= '0;
                q_proto_reg     <= '0;
                q_first_reg     <= '0;
                q_second_reg    <= '0;
                q_type_reg      <= '0;
                q_ident_reg     <= '0;
                q_seq_reg       <= '0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                outer_len_reg   <= outer_len_next;
                inner_len_reg   <= inner_len_next;
                outer_type_reg  <= outer_type_next;
                reply_ident_reg <= reply_ident_next;
                reply_seq_reg   <= reply_seq_next;
                q_proto_reg     <= q_proto_next;
                q_first_reg     <= q_first_next;
                q_second_reg    <= q_second_next;
                q_type_reg      <= q_type_next;
                q_ident_reg     <= q_ident_next;
                q_seq_reg       <= q_seq_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_W'(CAPTURE_BYTES))
        else $error("byte count past capture window");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pkt_data.last_byte |=> byte_count_reg == '0 && res_valid_reg)
        else $error("state not cleared or no result after last beat");

    a_hop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.verdict == VERDICT_NOT_OURS
        |-> res_data_reg.hop_address == 32'd0)
        else $error("hop address set on rejected packet");

    a_verdict_armed: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pkt_data.last_byte && !armed_reg |=> res_data_reg.verdict == VERDICT_NOT_OURS)
        else $error("verdict given while not armed");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |-> !pkt_ready)
        else $error("beat taken while result stalled");

endmodule

`default_nettype wire
